// ----- rtl/swl_pkg.sv -----
// Shared types and constants for the swing-low detector.
`timescale 1ns / 1ps
`default_nettype none

package swl_pkg;

  localparam int PRICE_W          = 32;
  localparam int HALF_W           = 5;
  localparam int MAX_HALF_DEF     = 16;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;

  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(5);

  // Register index taken from the word address bit of paddr.
  localparam logic REG_WINDOW_HALF = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic shift;   // take the accepted bar into the window
    logic commit;  // evaluate the centre bar and load the result register
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/swing_low_detector.sv -----
// Top level of the swing-low detector: configuration register, controller and datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bar per transfer: bar_low_i and
//   restart_i. A transfer happens on a rising edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per bar:
//   has_value_o, swing_low_o, new_swing_o.
//   The bar is shifted in on the transfer; the check state then loads the result register.
//   A new bar is stalled while in the check state; the window shift and the centre comparison
//   across all window taps are separate steps, done in the idle and check states.
//   A new bar is accepted while the previous result still waits in the output register;
//   if that result is stalled, the comparison holds until the register frees.
//   restart_i clears the bar count and the latched low before the bar is taken.
//   window_half is written over APB at byte address 0 and is read back there.
//   Reset: no result pending, bar count and latch cleared, window_half returns to 5.
//   The window itself has no reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module swing_low_detector #(
  parameter int MAX_HALF_WINDOW = swl_pkg::MAX_HALF_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [swl_pkg::PRICE_W-1:0]       bar_low_i,
  input  wire logic                              restart_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   has_value_o,
  output logic [swl_pkg::PRICE_W-1:0]            swing_low_o,
  output logic                                   new_swing_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [swl_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [swl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [swl_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  logic [swl_pkg::HALF_W-1:0] window_half_q;
  logic                       reg_sel;
  swl_pkg::cmd_t              cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == swl_pkg::REG_WINDOW_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_half_q <= swl_pkg::HALF_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_half_q <= pwdata[swl_pkg::HALF_W-1:0];
    end
  end

  always_comb begin
    if (reg_sel) begin
      prdata = swl_pkg::APB_DATA_W'(window_half_q);
    end else begin
      prdata = '0;
    end
  end

  swl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  swl_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .window_half_i (window_half_q),
    .bar_low_i     (bar_low_i),
    .restart_i     (restart_i),
    .has_value_o   (has_value_o),
    .swing_low_o   (swing_low_o),
    .new_swing_o   (new_swing_o)
  );

endmodule

`default_nettype wire

// ----- rtl/swl_ctrl.sv -----
// Controller for the swing-low detector: input and output handshakes, sequencing.
`timescale 1ns / 1ps
`default_nettype none

module swl_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output swl_pkg::cmd_t     cmd_o
);

  swl_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != swl_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swl_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = swl_pkg::ST_CHECK;
        end
      end
      swl_pkg::ST_CHECK: begin
        if (out_free) begin
          state_d = swl_pkg::ST_IDLE;
        end
      end
      default: state_d = swl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.shift  = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      swl_pkg::ST_IDLE:  cmd_o.shift  = accept;
      swl_pkg::ST_CHECK: cmd_o.commit = out_free;
      default: begin
        cmd_o.shift  = 1'b0;
        cmd_o.commit = 1'b0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == swl_pkg::ST_CHECK))
    else $error("accepted transfer did not start a check");

  a_check_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swl_pkg::ST_CHECK && !out_valid_q)
      |=> (state_q == swl_pkg::ST_IDLE && out_valid_q))
    else $error("check with free result register did not complete");

  a_result_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == swl_pkg::ST_CHECK))
    else $error("result appeared without a check");
`endif

endmodule

`default_nettype wire

// ----- rtl/swl_dp.sv -----
// Datapath for the swing-low detector: bar window, centre comparison, latch, result register.
`timescale 1ns / 1ps
`default_nettype none

module swl_dp #(
  parameter int MAX_HALF_WINDOW = swl_pkg::MAX_HALF_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire swl_pkg::cmd_t                 cmd_i,
  input  wire logic [swl_pkg::HALF_W-1:0]    window_half_i,
  input  wire logic [swl_pkg::PRICE_W-1:0]   bar_low_i,
  input  wire logic                          restart_i,
  output logic                               has_value_o,
  output logic [swl_pkg::PRICE_W-1:0]        swing_low_o,
  output logic                               new_swing_o
);

  localparam int Depth = 2 * MAX_HALF_WINDOW + 1;
  localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int IW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  logic [swl_pkg::PRICE_W-1:0] taps_q [Depth];
  logic [CW-1:0]               bars_q, bars_d;
  logic [swl_pkg::PRICE_W-1:0] latch_low_q;
  logic                        latch_valid_q;
  logic                        has_q;
  logic [swl_pkg::PRICE_W-1:0] low_q;
  logic                        new_q;

  logic [HW-1:0]               h;
  logic [IW-1:0]               span;
  logic [swl_pkg::PRICE_W-1:0] centre;
  logic [Depth-1:0]            ok;
  logic                        warm;
  logic                        found;

  // Half window clamped to 1..MAX_HALF_WINDOW.
  always_comb begin
    if (window_half_i == '0) begin
      h = HW'(1);
    end else if (int'(window_half_i) > MAX_HALF_WINDOW) begin
      h = HW'(MAX_HALF_WINDOW);
    end else begin
      h = HW'(window_half_i);
    end
  end

  assign span   = IW'({h, 1'b0});
  assign centre = taps_q[IW'(h)];
  assign warm   = (bars_q >= CW'({h, 1'b1}));

  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      ok[k] = !((IW'(k) <= span) && (IW'(k) != IW'(h))) || (taps_q[k] >= centre);
    end
  end

  assign found = warm && (&ok);

  always_comb begin
    if (restart_i) begin
      bars_d = CW'(1);
    end else if (int'(bars_q) < Depth) begin
      bars_d = bars_q + CW'(1);
    end else begin
      bars_d = bars_q;
    end
  end

  // Window taps hold no reset; only ever read once written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      taps_q[0] <= bar_low_i;
      for (int k = 1; k < Depth; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bars_q        <= '0;
      latch_low_q   <= '0;
      latch_valid_q <= 1'b0;
      has_q         <= 1'b0;
      low_q         <= '0;
      new_q         <= 1'b0;
    end else begin
      if (cmd_i.shift) begin
        bars_q <= bars_d;
        if (restart_i) begin
          latch_low_q   <= '0;
          latch_valid_q <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        new_q <= found;
        if (found) begin
          latch_low_q   <= centre;
          latch_valid_q <= 1'b1;
          has_q         <= 1'b1;
          low_q         <= centre;
        end else begin
          has_q <= latch_valid_q;
          low_q <= latch_low_q;
        end
      end
    end
  end

  assign has_value_o = has_q;
  assign swing_low_o = low_q;
  assign new_swing_o = new_q;

`ifndef SYNTHESIS
  a_new_implies_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_q |-> has_q)
    else $error("new swing flagged without a latched value");

  a_empty_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !latch_valid_q |-> (latch_low_q == '0))
    else $error("latched low nonzero while latch empty");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |=> (int'(bars_q) <= Depth) && (bars_q != '0))
    else $error("bar count out of range after shift");
`endif

endmodule

`default_nettype wire
